FILE: rtl/core/mlfm_pkg.sv
// Shared types and constants for the mains level fault monitor.
// Holds the sample width, the configuration register map and the event codes.
// Depends on nothing; every other file of the block imports it.
package mlfm_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int THRESH_BITS = 10;
    localparam int CMP_W = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int PHASE_BITS = 16;
    localparam int CONFIRM_BITS = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENABLE          = 3'd0,
        CFG_IDLE_TICKS      = 3'd1,
        CFG_WINDOW_TICKS    = 3'd2,
        CFG_TRIP_HIGH       = 3'd3,
        CFG_TRIP_LOW        = 3'd4,
        CFG_CLEAR_HIGH      = 3'd5,
        CFG_CLEAR_LOW       = 3'd6,
        CFG_CONFIRM_WINDOWS = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_RAISED  = 2'd1,
        EV_CLEARED = 2'd2
    } event_t;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic                    enable;
        logic [PHASE_BITS-1:0]   idle_ticks;
        logic [PHASE_BITS-1:0]   window_ticks;
        logic [THRESH_BITS-1:0]  trip_high;
        logic [THRESH_BITS-1:0]  trip_low;
        logic [THRESH_BITS-1:0]  clear_high;
        logic [THRESH_BITS-1:0]  clear_low;
        logic [CONFIRM_BITS-1:0] confirm_windows;
    } cfg_t;

endpackage

FILE: rtl/core/mains_level_fault_monitor_unit.sv
// Top level of the mains level fault monitor: input register, phase and peak logic,
// window judgment with debounce, and the result register.
// Depends on mlfm_pkg and mlfm_cfg_regs.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      s_req_type, s_sample
//  m_        out        m_valid / m_ready      m_sampling, m_fault, m_event_res
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle is sustained while m_ready holds; each is held in the input register,
// and its result is loaded into the result register when it advances.
// Reset is synchronous and clears all monitor state and restores the default settings.
// A stalled result keeps one further transaction in the input register before s_ready drops.
module mains_level_fault_monitor_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_req_type,
    input  logic [mlfm_pkg::SAMPLE_BITS-1:0]      s_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_sampling,
    output logic                                  m_fault,
    output logic [1:0]                            m_event_res,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mlfm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mlfm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import mlfm_pkg::*;

    cfg_t cfg;

    mlfm_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic                    in_valid_reg;
    logic                    in_req_reg;
    logic [SAMPLE_BITS-1:0]  in_sample_reg;

    logic [PHASE_BITS-1:0]   phase_reg,   phase_next;
    logic                    window_reg,  window_next;
    logic [SAMPLE_BITS-1:0]  peak_reg,    peak_next;
    logic [CONFIRM_BITS-1:0] confirm_reg, confirm_next;
    logic                    fault_reg,   fault_next;
    event_t                  event_next;

    logic                    out_valid_reg;
    logic                    out_sampling_reg;
    logic                    out_fault_reg;
    event_t                  out_event_reg;

    logic                    advance;
    logic [PHASE_BITS-1:0]   phase_inc;
    logic [CONFIRM_BITS-1:0] confirm_inc;
    logic [CMP_W-1:0]        peak_cmp;
    logic                    qualifies;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign phase_inc   = phase_reg + PHASE_BITS'(1);
    assign confirm_inc = confirm_reg + CONFIRM_BITS'(1);
    assign peak_cmp    = CMP_W'(peak_reg);

    always_comb begin
        if (fault_reg) begin
            qualifies = (peak_cmp <= CMP_W'(cfg.clear_high)) &&
                        (peak_cmp >= CMP_W'(cfg.clear_low));
        end else begin
            qualifies = (peak_cmp >= CMP_W'(cfg.trip_high)) ||
                        (peak_cmp <= CMP_W'(cfg.trip_low));
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        window_next  = window_reg;
        peak_next    = peak_reg;
        confirm_next = confirm_reg;
        fault_next   = fault_reg;
        event_next   = EV_NONE;
        if (in_req_reg == REQ_SAMPLE) begin
            if (window_reg && (in_sample_reg > peak_reg)) begin
                peak_next = in_sample_reg;
            end
        end else if (cfg.enable) begin
            phase_next = phase_inc;
            if (!window_reg) begin
                if (phase_inc >= cfg.idle_ticks) begin
                    phase_next  = '0;
                    window_next = 1'b1;
                end
            end else if (phase_inc >= cfg.window_ticks) begin
                phase_next  = '0;
                window_next = 1'b0;
                peak_next   = '0;
                if (qualifies) begin
                    if (confirm_inc >= cfg.confirm_windows) begin
                        confirm_next = '0;
                        fault_next   = !fault_reg;
                        event_next   = fault_reg ? EV_CLEARED : EV_RAISED;
                    end else begin
                        confirm_next = confirm_inc;
                    end
                end else begin
                    confirm_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            window_reg    <= 1'b0;
            peak_reg      <= '0;
            confirm_reg   <= '0;
            fault_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg   <= phase_next;
                window_reg  <= window_next;
                peak_reg    <= peak_next;
                confirm_reg <= confirm_next;
                fault_reg   <= fault_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg    <= s_req_type;
            in_sample_reg <= s_sample;
        end
        if (advance) begin
            out_sampling_reg <= window_next;
            out_fault_reg    <= fault_next;
            out_event_reg    <= event_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_sampling  = out_sampling_reg;
    assign m_fault     = out_fault_reg;
    assign m_event_res = out_event_reg;

    // A raised event always reports the fault as present, a cleared one as absent.
    a_event_matches_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res != EV_NONE) |-> (m_fault == (m_event_res == EV_RAISED)))
        else $error("event code disagrees with fault flag");

    // Events only arise when a window closes.
    a_event_closes_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res != EV_NONE) |-> !m_sampling)
        else $error("event reported while window still open");

    // The fault flag moves only when a transaction is processed.
    a_fault_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(fault_reg))
        else $error("fault flag changed without a transaction");

    // The peak hold stays cleared while the window is closed.
    a_peak_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !window_reg |-> (peak_reg == '0))
        else $error("peak held outside the sampling window");

endmodule

FILE: rtl/core/mlfm_cfg_regs.sv
// Configuration register file of the mains level fault monitor.
// Decodes writes from the configuration channel into the settings struct.
// Depends on mlfm_pkg.
module mlfm_cfg_regs (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mlfm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mlfm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output mlfm_pkg::cfg_t                        cfg
);
    import mlfm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ENABLE:          cfg_next.enable = cfg_data[0];
                CFG_IDLE_TICKS:      cfg_next.idle_ticks = cfg_data[PHASE_BITS-1:0];
                CFG_WINDOW_TICKS:    cfg_next.window_ticks = cfg_data[PHASE_BITS-1:0];
                CFG_TRIP_HIGH:       cfg_next.trip_high = cfg_data[THRESH_BITS-1:0];
                CFG_TRIP_LOW:        cfg_next.trip_low = cfg_data[THRESH_BITS-1:0];
                CFG_CLEAR_HIGH:      cfg_next.clear_high = cfg_data[THRESH_BITS-1:0];
                CFG_CLEAR_LOW:       cfg_next.clear_low = cfg_data[THRESH_BITS-1:0];
                CFG_CONFIRM_WINDOWS: cfg_next.confirm_windows = cfg_data[CONFIRM_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable          <= 1'b1;
            cfg_reg.idle_ticks      <= PHASE_BITS'(70);
            cfg_reg.window_ticks    <= PHASE_BITS'(2);
            cfg_reg.trip_high       <= THRESH_BITS'(400);
            cfg_reg.trip_low        <= THRESH_BITS'(210);
            cfg_reg.clear_high      <= THRESH_BITS'(400);
            cfg_reg.clear_low       <= THRESH_BITS'(200);
            cfg_reg.confirm_windows <= CONFIRM_BITS'(2);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
